// ===== src/jsu_pkg.sv =====
// shared types and constants for the json string unescape block
// no dependencies; every other source file except jsu_if.sv imports this package
package jsu_pkg;

    // decoder modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX,
        MODE_HIGH,
        MODE_HIGH_BS,
        MODE_DONE,
        MODE_ERR
    } t_mode;

    // error codes carried on the result beat
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_QUOTE = 3'd1,
        ERR_BAD_ESC  = 3'd2,
        ERR_BAD_HEX  = 3'd3,
        ERR_UNTERM   = 3'd4
    } t_err;

    // main operation of a queued command
    typedef enum logic [1:0] {
        OP_NONE,
        OP_RAW,
        OP_CP,
        OP_EVENT
    } t_op;

    localparam int CP_W = 21;

    // one command from the front end: optional replacement char, then the main op
    typedef struct packed {
        logic            pre_repl;
        t_op             op;
        logic [CP_W-1:0] val;
        logic            closed;
        t_err            err;
    } t_cmd;

    // push request from the front end into the queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        t_cmd head;
    } t_qhead;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // index width for the longest result run of one command (replacement char plus a 3-byte char)
    localparam int RUN_W = 3;

    // characters and code point bounds
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_LC_B   = 8'h62;
    localparam logic [7:0]  CH_LC_F   = 8'h66;
    localparam logic [7:0]  CH_LC_N   = 8'h6E;
    localparam logic [7:0]  CH_LC_R   = 8'h72;
    localparam logic [7:0]  CH_LC_T   = 8'h74;
    localparam logic [7:0]  CH_LC_U   = 8'h75;
    localparam logic [7:0]  CH_LC_A   = 8'h61;
    localparam logic [7:0]  CH_UC_A   = 8'h41;
    localparam logic [7:0]  CH_UC_F   = 8'h46;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CTL_BS    = 8'h08;
    localparam logic [7:0]  CTL_FF    = 8'h0C;
    localparam logic [7:0]  CTL_LF    = 8'h0A;
    localparam logic [7:0]  CTL_CR    = 8'h0D;
    localparam logic [7:0]  CTL_TAB   = 8'h09;

    localparam logic [15:0] HI_SUR_LO = 16'hD800;
    localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SUR_LO = 16'hDC00;
    localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
    localparam logic [CP_W-1:0] CP_REPL  = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX1  = 21'h00007F;
    localparam logic [CP_W-1:0] CP_MAX2  = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_MAX3  = 21'h00FFFF;

endpackage

// ===== src/jsu_if.sv =====
// valid/ready channel interfaces for the input text and the decoded output
// depends on nothing but the port roles; payload widths are fixed
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       closed;
    logic [2:0] error;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output closed,
                    output error, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input closed,
                    input error, input last, output ready);
endinterface

// ===== src/jsu_front.sv =====
// front end: accepts text beats, tracks the string/escape/surrogate state
// and turns each beat into at most one command; uses jsu_pkg and jsu_in_if
module jsu_front
    import jsu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    jsu_in_if.sink       i_in,
    input  logic         i_full,
    output t_push        o_push
);

    t_mode        r_mode,    n_mode;
    logic [15:0]  r_acc,     n_acc;
    logic [1:0]   r_cnt,     n_cnt;
    logic [9:0]   r_pend,    n_pend;
    logic         r_low,     n_low;

    logic         accept;
    logic [7:0]   c;
    t_cmd         cmd;

    // simple escape letter lookup
    function automatic logic [8:0] esc_map(input logic [7:0] ch);
        logic [8:0] r;
        r = 9'd0;
        unique case (ch)
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_SLASH:  r = {1'b1, CH_SLASH};
            CH_LC_B:   r = {1'b1, CTL_BS};
            CH_LC_F:   r = {1'b1, CTL_FF};
            CH_LC_N:   r = {1'b1, CTL_LF};
            CH_LC_R:   r = {1'b1, CTL_CR};
            CH_LC_T:   r = {1'b1, CTL_TAB};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    // hex digit decode: valid flag and nibble
    function automatic logic [4:0] hex_map(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        priority if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = ch - CH_ZERO;
            return {1'b1, d[3:0]};
        end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
            d = ch - CH_LC_A + 8'd10;
            return {1'b1, d[3:0]};
        end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
            d = ch - CH_UC_A + 8'd10;
            return {1'b1, d[3:0]};
        end else begin
            return 5'd0;
        end
    endfunction

    function automatic logic is_high(input logic [15:0] v);
        return (v >= HI_SUR_LO) && (v <= HI_SUR_HI);
    endfunction

    function automatic logic is_low(input logic [15:0] v);
        return (v >= LO_SUR_LO) && (v <= LO_SUR_HI);
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.data_byte;

    // per-beat decode
    always_comb begin
        logic [8:0]  esc;
        logic [4:0]  hx;
        logic [15:0] v;
        logic        fresh;

        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_pend = r_pend;
        n_low  = r_low;
        cmd    = '0;
        esc    = esc_map(c);
        hx     = hex_map(c);
        v      = {r_acc[11:0], hx[3:0]};
        fresh  = 1'b0;

        if (accept) begin
            if (i_in.kind) begin
                // end marker
                if (r_mode == MODE_IDLE) begin
                    cmd.op  = OP_EVENT;
                    cmd.err = ERR_NO_QUOTE;
                end else if (r_mode != MODE_DONE && r_mode != MODE_ERR) begin
                    cmd.op  = OP_EVENT;
                    cmd.err = ERR_UNTERM;
                end
                n_mode = MODE_IDLE;
                n_acc  = '0;
                n_cnt  = '0;
                n_pend = '0;
                n_low  = 1'b0;
            end else begin
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (c == CH_QUOTE) begin
                            n_mode = MODE_BODY;
                        end else begin
                            cmd.op  = OP_EVENT;
                            cmd.err = ERR_NO_QUOTE;
                            n_mode  = MODE_ERR;
                        end
                    end
                    MODE_BODY, MODE_HIGH: begin
                        // a pending high half not followed by a backslash is replaced
                        if (r_mode == MODE_HIGH && c == CH_BSLASH) begin
                            n_mode = MODE_HIGH_BS;
                        end else begin
                            cmd.pre_repl = (r_mode == MODE_HIGH);
                            if (c == CH_QUOTE) begin
                                cmd.op     = OP_EVENT;
                                cmd.closed = 1'b1;
                                n_mode     = MODE_DONE;
                            end else if (c == CH_BSLASH) begin
                                n_mode = MODE_ESC;
                            end else begin
                                cmd.op  = OP_RAW;
                                cmd.val = {13'd0, c};
                                n_mode  = MODE_BODY;
                            end
                        end
                    end
                    MODE_ESC, MODE_HIGH_BS: begin
                        if (c == CH_LC_U) begin
                            n_acc  = '0;
                            n_cnt  = '0;
                            n_low  = (r_mode == MODE_HIGH_BS);
                            n_mode = MODE_HEX;
                        end else begin
                            cmd.pre_repl = (r_mode == MODE_HIGH_BS);
                            if (esc[8]) begin
                                cmd.op  = OP_RAW;
                                cmd.val = {13'd0, esc[7:0]};
                                n_mode  = MODE_BODY;
                            end else begin
                                cmd.op  = OP_EVENT;
                                cmd.err = ERR_BAD_ESC;
                                n_mode  = MODE_ERR;
                            end
                        end
                    end
                    MODE_HEX: begin
                        if (!hx[4]) begin
                            cmd.op  = OP_EVENT;
                            cmd.err = ERR_BAD_HEX;
                            n_mode  = MODE_ERR;
                        end else begin
                            n_acc = v;
                            if (r_cnt == 2'd3) begin
                                n_cnt = '0;
                                // four digits in: pair, replace or take as a fresh unit
                                if (r_low) begin
                                    n_low = 1'b0;
                                    if (is_low(v)) begin
                                        cmd.op  = OP_CP;
                                        cmd.val = {1'b0, r_pend, v[9:0]} + CP_SUPP;
                                        n_mode  = MODE_BODY;
                                    end else begin
                                        cmd.pre_repl = 1'b1;
                                        fresh        = 1'b1;
                                    end
                                end else begin
                                    fresh = 1'b1;
                                end
                                if (fresh) begin
                                    if (is_high(v)) begin
                                        n_pend = v[9:0];
                                        n_mode = MODE_HIGH;
                                    end else if (is_low(v)) begin
                                        cmd.op  = OP_CP;
                                        cmd.val = CP_REPL;
                                        n_mode  = MODE_BODY;
                                    end else begin
                                        cmd.op  = OP_CP;
                                        cmd.val = {5'd0, v};
                                        n_mode  = MODE_BODY;
                                    end
                                end
                            end else begin
                                n_cnt = r_cnt + 2'd1;
                            end
                        end
                    end
                    MODE_DONE, MODE_ERR: begin
                    end
                    default: begin
                    end
                endcase
            end
        end

        o_push.valid = cmd.pre_repl || (cmd.op != OP_NONE);
        o_push.cmd   = cmd;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
            r_low  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
            r_low  <= n_low;
        end
    end

endmodule

// ===== src/jsu_fifo.sv =====
// short command queue between the front and back ends
// uses jsu_pkg for the command type and depth
module jsu_fifo
    import jsu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
        if (p == Q_AW'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + Q_AW'(1);
    endfunction

    assign o_full       = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_head.empty = (r_cnt == '0);
    assign o_head.head  = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    // pointer and count update
    always_comb begin
        n_wr  = do_push ? bump(r_wr) : r_wr;
        n_rd  = do_pop  ? bump(r_rd) : r_rd;
        n_cnt = r_cnt + (Q_AW + 1)'(do_push) - (Q_AW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

endmodule

// ===== src/jsu_back.sv =====
// back end: walks each queued command one result beat per cycle while the
// output is ready, and encodes code points to UTF-8; uses jsu_pkg and jsu_out_if
module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qhead    i_head,
    output logic      o_pop,
    jsu_out_if.source o_out
);

    logic [RUN_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_bval, n_bval;
    logic             r_closed, n_closed;
    logic [2:0]       r_err, n_err;
    logic             r_last, n_last;

    // utf-8 length of a code point
    function automatic logic [2:0] cp_len(input logic [CP_W-1:0] cp);
        priority if (cp <= CP_MAX1) begin
            return 3'd1;
        end else if (cp <= CP_MAX2) begin
            return 3'd2;
        end else if (cp <= CP_MAX3) begin
            return 3'd3;
        end else begin
            return 3'd4;
        end
    endfunction

    // byte j of the utf-8 encoding of cp, given its length
    function automatic logic [7:0] cp_byte(input logic [CP_W-1:0] cp, input logic [2:0] len,
                                           input logic [2:0] j);
        logic [7:0] b;
        b = 8'd0;
        if (j == 3'd0) begin
            unique case (len)
                3'd1:    b = cp[7:0];
                3'd2:    b = {3'b110, cp[10:6]};
                3'd3:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            // continuation bytes count down from the top six-bit group
            unique case (len - j)
                3'd1:    b = {2'b10, cp[5:0]};
                3'd2:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

    // output register stage
    always_comb begin
        t_cmd             h;
        logic [2:0]       mlen;
        logic [RUN_W-1:0] total;
        logic [RUN_W-1:0] off;
        logic [2:0]       j;
        logic             adv;

        h       = i_head.head;
        unique case (h.op)
            OP_NONE:  mlen = 3'd0;
            OP_CP:    mlen = cp_len(h.val);
            default:  mlen = 3'd1;
        endcase
        off     = h.pre_repl ? RUN_W'(3) : RUN_W'(0);
        total   = off + mlen;
        j       = r_idx - off;
        adv     = !r_valid || o_out.ready;

        n_idx    = r_idx;
        n_valid  = r_valid;
        n_byte   = r_byte;
        n_bval   = r_bval;
        n_closed = r_closed;
        n_err    = r_err;
        n_last   = r_last;
        o_pop    = 1'b0;

        if (adv) begin
            n_valid = !i_head.empty;
            if (!i_head.empty) begin
                n_closed = 1'b0;
                n_err    = ERR_NONE;
                n_bval   = 1'b1;
                n_byte   = 8'd0;
                if (h.pre_repl && r_idx < RUN_W'(3)) begin
                    n_byte = cp_byte(CP_REPL, 3'd3, r_idx);
                end else begin
                    unique case (h.op)
                        OP_RAW:  n_byte = h.val[7:0];
                        OP_CP:   n_byte = cp_byte(h.val, mlen, j);
                        default: begin
                            n_bval   = 1'b0;
                            n_closed = h.closed;
                            n_err    = h.err;
                        end
                    endcase
                end
                n_last = (r_idx == total - RUN_W'(1));
                if (n_last) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + RUN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_bval   <= n_bval;
        r_closed <= n_closed;
        r_err    <= n_err;
        r_last   <= n_last;
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.byte_valid = r_bval;
    assign o_out.closed     = r_closed;
    assign o_out.error      = r_err;
    assign o_out.last       = r_last;

endmodule

// ===== src/json_string_unescape_utf8.sv =====
// JSON string literal decoder to UTF-8. Input beats carry one text byte (kind 0) or an end
// marker (kind 1); the front end takes one beat per cycle whenever its four-entry command queue
// has room, and each beat yields at most one command. The back end turns every command into
// its result beats at one beat per cycle while the receiver is ready, through a registered
// output, so a plain byte yields one result beat, a \u escape one to four, and an unpaired
// surrogate followed by more text up to six. Sustained input rate is one beat per cycle while
// the output side keeps pace with the bytes produced; escapes that expand stall the input only
// once the queue fills. A beat's command passes through the queue and the output register.
// top level: jsu_front, jsu_fifo, jsu_back; uses jsu_pkg and jsu_if
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    t_push  push;
    t_qhead qhead;
    logic   q_full;
    logic   q_pop;

    // beat classification and state
    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push)
    );

    // command queue
    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (qhead)
    );

    // utf-8 expansion and output register
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (qhead),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    // no command is ever offered to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_full)
        else $error("command pushed into full queue");

    // a decoded byte never carries an event flag
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.byte_valid) |-> (o_out.error == ERR_NONE && !o_out.closed))
        else $error("byte beat carries event flags");

    // queued work reaches the output as soon as the register is free
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!qhead.empty && (!o_out.valid || o_out.ready)) |=> o_out.valid)
        else $error("queued command not moved to output");

    // output register is empty straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for json_string_unescape_utf8: directed strings, then random text
// depends on jsu_pkg (types, characters, code point bounds) and the jsu_in_if/jsu_out_if channels
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int HOLD_CYCLES  = 200;
    localparam int WDOG_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_ITEMS = 10;
    localparam int REPORT_MAX   = 10;
    localparam int N_ESC        = 8;

    localparam logic [7:0] ESC_LETTERS [N_ESC] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                                   CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

    // one decoded output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       closed;
        logic [2:0] error;
        logic       last;
    } t_utf8_beat;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #4 clk = ~clk;

    // decoder state mirrored by the bench
    t_mode       dec_mode;
    logic [15:0] dec_acc;
    logic [1:0]  dec_cnt;
    logic [9:0]  dec_high;
    logic        dec_low_half;

    t_utf8_beat beat_results[$];
    t_utf8_beat expected_utf8[$];

    int  fail_cnt       = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  strings_closed = 0;
    int  error_reports  = 0;
    int  burst_left     = 0;
    bit  hold_pending   = 1'b0;

    // ---------------------------------------------------------------- decoder prediction

    function automatic void add_beat(logic [7:0] b, logic bv, logic cl, t_err e);
        t_utf8_beat r;
        r.out_byte   = b;
        r.byte_valid = bv;
        r.closed     = cl;
        r.error      = e;
        r.last       = 1'b0;
        beat_results.insert(beat_results.size(), r);
    endfunction

    function automatic void emit_char(logic [7:0] b);
        add_beat(b, 1'b1, 1'b0, ERR_NONE);
    endfunction

    function automatic void raise_error(t_err e);
        add_beat(8'h00, 1'b0, 1'b0, e);
        dec_mode = MODE_ERR;
    endfunction

    function automatic void clear_decoder();
        dec_mode     = MODE_IDLE;
        dec_acc      = '0;
        dec_cnt      = '0;
        dec_high     = '0;
        dec_low_half = 1'b0;
    endfunction

    // utf-8 bytes of one code point
    function automatic void utf8_encode(logic [CP_W-1:0] cp);
        if (cp <= CP_MAX1) begin
            emit_char(cp[7:0]);
        end else if (cp <= CP_MAX2) begin
            emit_char({3'b110, cp[10:6]});
            emit_char({2'b10, cp[5:0]});
        end else if (cp <= CP_MAX3) begin
            emit_char({4'b1110, cp[15:12]});
            emit_char({2'b10, cp[11:6]});
            emit_char({2'b10, cp[5:0]});
        end else begin
            emit_char({5'b11110, cp[20:18]});
            emit_char({2'b10, cp[17:12]});
            emit_char({2'b10, cp[11:6]});
            emit_char({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void text_char(logic [7:0] c);
        if (c == CH_QUOTE) begin
            add_beat(8'h00, 1'b0, 1'b1, ERR_NONE);
            dec_mode = MODE_DONE;
        end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            emit_char(c);
        end
    endfunction

    function automatic void open_hex(logic low_half);
        dec_acc      = '0;
        dec_cnt      = '0;
        dec_low_half = low_half;
        dec_mode     = MODE_HEX;
    endfunction

    function automatic void escape_letter(logic [7:0] c);
        logic [7:0] o;
        logic       simple;
        o      = 8'h00;
        simple = 1'b1;
        case (c)
            CH_QUOTE:  o = CH_QUOTE;
            CH_BSLASH: o = CH_BSLASH;
            CH_SLASH:  o = CH_SLASH;
            CH_LC_B:   o = CTL_BS;
            CH_LC_F:   o = CTL_FF;
            CH_LC_N:   o = CTL_LF;
            CH_LC_R:   o = CTL_CR;
            CH_LC_T:   o = CTL_TAB;
            CH_LC_U: begin
                open_hex(1'b0);
                simple = 1'b0;
            end
            default: begin
                raise_error(ERR_BAD_ESC);
                simple = 1'b0;
            end
        endcase
        if (simple) begin
            emit_char(o);
            dec_mode = MODE_BODY;
        end
    endfunction

    // a complete code unit that is not the low half of a pair
    function automatic void code_unit(logic [15:0] v);
        if (v >= HI_SUR_LO && v <= HI_SUR_HI) begin
            dec_high = v[9:0];
            dec_mode = MODE_HIGH;
        end else begin
            if (v >= LO_SUR_LO && v <= LO_SUR_HI)
                utf8_encode(CP_REPL);
            else
                utf8_encode({5'd0, v});
            dec_mode = MODE_BODY;
        end
    endfunction

    function automatic void unit_complete(logic [15:0] v);
        logic [CP_W-1:0] cp;
        if (dec_low_half) begin
            dec_low_half = 1'b0;
            if (v >= LO_SUR_LO && v <= LO_SUR_HI) begin
                cp = CP_SUPP + {1'b0, dec_high, 10'd0} + {5'd0, v - LO_SUR_LO};
                utf8_encode(cp);
                dec_mode = MODE_BODY;
            end else begin
                utf8_encode(CP_REPL);
                code_unit(v);
            end
        end else begin
            code_unit(v);
        end
    endfunction

    function automatic void hex_digit(logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'h00;
        ok = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_LC_A && c <= CH_LC_F)
            d = c - CH_LC_A + 8'd10;
        else if (c >= CH_UC_A && c <= CH_UC_F)
            d = c - CH_UC_A + 8'd10;
        else
            ok = 1'b0;
        if (!ok) begin
            raise_error(ERR_BAD_HEX);
        end else begin
            dec_acc = {dec_acc[11:0], d[3:0]};
            if (dec_cnt == 2'd3) begin
                dec_cnt = 2'd0;
                unit_complete(dec_acc);
            end else begin
                dec_cnt = dec_cnt + 2'd1;
            end
        end
    endfunction

    // expected result beats of one accepted input beat
    function automatic void decode_text_beat(logic kind, logic [7:0] c);
        t_utf8_beat r;
        beat_results.delete();
        if (kind == KIND_END) begin
            if (dec_mode == MODE_IDLE)
                add_beat(8'h00, 1'b0, 1'b0, ERR_NO_QUOTE);
            else if (dec_mode != MODE_DONE && dec_mode != MODE_ERR)
                add_beat(8'h00, 1'b0, 1'b0, ERR_UNTERM);
            clear_decoder();
        end else begin
            case (dec_mode)
                MODE_IDLE: begin
                    if (c == CH_QUOTE)
                        dec_mode = MODE_BODY;
                    else
                        raise_error(ERR_NO_QUOTE);
                end
                MODE_BODY: text_char(c);
                MODE_ESC:  escape_letter(c);
                MODE_HEX:  hex_digit(c);
                MODE_HIGH: begin
                    if (c == CH_BSLASH) begin
                        dec_mode = MODE_HIGH_BS;
                    end else begin
                        utf8_encode(CP_REPL);
                        dec_mode = MODE_BODY;
                        text_char(c);
                    end
                end
                MODE_HIGH_BS: begin
                    if (c == CH_LC_U) begin
                        open_hex(1'b1);
                    end else begin
                        utf8_encode(CP_REPL);
                        escape_letter(c);
                    end
                end
                default: ;
            endcase
        end
        if (beat_results.size() > 0) begin
            r = beat_results[beat_results.size() - 1];
            r.last = 1'b1;
            beat_results[beat_results.size() - 1] = r;
        end
        foreach (beat_results[i])
            expected_utf8.insert(expected_utf8.size(), beat_results[i]);
    endfunction

    // ---------------------------------------------------------------- character helpers

    function automatic bit is_escape_letter(logic [7:0] c);
        for (int i = 0; i < N_ESC; i++)
            if (ESC_LETTERS[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LC_A && c <= CH_LC_F) ||
               (c >= CH_UC_A && c <= CH_UC_F);
    endfunction

    // hex digit in random case
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + {4'd0, n};
        return (($urandom_range(0, 1) == 0) ? CH_UC_A : CH_LC_A) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] plain_text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] bad_escape_letter();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c) || c == CH_LC_U);
        return c;
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_hex(c));
        return c;
    endfunction

    // ---------------------------------------------------------------- input side

    // one input beat, with bursts and random gaps in front of it
    task automatic send_beat(input logic kind, input logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        decode_text_beat(kind, b);
        items_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(KIND_DATA, s[i]);
    endtask

    // end marker; its data byte is don't-care
    task automatic send_end();
        send_beat(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_u(input logic [15:0] v);
        send_beat(KIND_DATA, CH_BSLASH);
        send_beat(KIND_DATA, CH_LC_U);
        for (int i = 3; i >= 0; i--)
            send_beat(KIND_DATA, hex_char(v[4*i +: 4]));
    endtask

    // sender idles until every expected beat has come back
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_utf8.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- output side

    // ready pacing: random 16-bit patterns, some all-ready, plus one long hold on request
    initial begin : rx_pacing
        int          ph;
        logic [15:0] pat;
        ph  = 0;
        pat = '1;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (ph == 0) begin
                case ($urandom_range(0, 3))
                    0: pat = '1;
                    1: pat = 16'($urandom);
                    2: pat = 16'($urandom | $urandom);
                    default: pat = 16'($urandom & $urandom);
                endcase
            end
            out_ch.ready <= pat[ph];
            ph = (ph + 1) % 16;
        end
    end

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // compare each accepted result beat against the oldest expectation
    task automatic check_result();
        t_utf8_beat want;
        t_utf8_beat got;
        got.out_byte   = out_ch.out_byte;
        got.byte_valid = out_ch.byte_valid;
        got.closed     = out_ch.closed;
        got.error      = out_ch.error;
        got.last       = out_ch.last;
        results_seen++;
        if (got.closed === 1'b1)
            strings_closed++;
        if (got.error !== ERR_NONE)
            error_reports++;
        if (expected_utf8.size() == 0) begin
            note_failure($sformatf("unexpected beat: byte %02h bv %0b closed %0b err %0d last %0b",
                                   got.out_byte, got.byte_valid, got.closed, got.error,
                                   got.last));
        end else begin
            want = expected_utf8.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.closed !== want.closed || got.error !== want.error ||
                got.last !== want.last)
                note_failure($sformatf({"beat %0d: expected byte %02h bv %0b closed %0b ",
                                        "err %0d last %0b, got byte %02h bv %0b closed %0b ",
                                        "err %0d last %0b"}, results_seen,
                                       want.out_byte, want.byte_valid, want.closed,
                                       want.error, want.last, got.out_byte, got.byte_valid,
                                       got.closed, got.error, got.last));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
    end

    // no beat on either side for too long ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d beats still expected",
                 WDOG_LIMIT, expected_utf8.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // end marker while idle, missing quote, empty string, bytes after close/error, unterminated string
    task automatic test_framing();
        send_end();
        send_str("x!");
        send_end();
        send_str("\"\"z");
        send_end();
        send_str("\"ab");
        send_end();
    endtask

    // raw byte extremes and every simple escape
    task automatic test_simple_escapes();
        send_beat(KIND_DATA, CH_QUOTE);
        send_beat(KIND_DATA, 8'h00);
        send_beat(KIND_DATA, 8'hFF);
        send_str("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        send_end();
    endtask

    // smallest code unit of the two- and three-byte utf-8 lengths and the largest one
    task automatic test_code_unit_widths();
        send_beat(KIND_DATA, CH_QUOTE);
        send_u(16'h0080);
        send_u(16'h0800);
        send_u(16'hFFFF);
        send_beat(KIND_DATA, CH_QUOTE);
        send_end();
    endtask

    // lowest and highest supplementary code points
    task automatic test_surrogate_pairs();
        send_beat(KIND_DATA, CH_QUOTE);
        send_u(HI_SUR_LO);
        send_u(LO_SUR_LO);
        send_u(HI_SUR_HI);
        send_u(LO_SUR_HI);
        send_beat(KIND_DATA, CH_QUOTE);
        send_end();
    endtask

    task automatic test_unpaired_surrogates();
        send_beat(KIND_DATA, CH_QUOTE);
        // high half then plain text
        send_u(16'hD83D);
        send_beat(KIND_DATA, "A");
        // high half, backslash, other escape letter
        send_u(16'hDBFF);
        send_str("\\n");
        // high half then a unit that is no low half
        send_u(16'hD800);
        send_u(16'h0041);
        // lone low half
        send_u(16'hDC00);
        // high half then closing quote
        send_u(16'hDABC);
        send_beat(KIND_DATA, CH_QUOTE);
        send_end();
        // high half then bad escape letter
        send_beat(KIND_DATA, CH_QUOTE);
        send_u(16'hD800);
        send_str("\\q");
        send_end();
        // high half dropped by the end marker after its backslash
        send_beat(KIND_DATA, CH_QUOTE);
        send_u(16'hD800);
        send_beat(KIND_DATA, CH_BSLASH);
        send_end();
        // bad hex digit in the low half
        send_beat(KIND_DATA, CH_QUOTE);
        send_u(16'hD800);
        send_str("\\u0G");
        send_end();
    endtask

    task automatic test_error_cases();
        send_str("\"\\q");
        send_end();
        send_str("\"\\u1G");
        send_end();
        send_str("\"\\u1");
        send_end();
    endtask

    // receiver stalls for a long stretch while characters keep coming
    task automatic test_output_backpressure();
        logic [15:0] v;
        hold_pending = 1'b1;
        send_beat(KIND_DATA, CH_QUOTE);
        repeat (3) begin
            v = 16'($urandom_range(16'h0800, 16'hF7FF));
            if (v >= HI_SUR_LO)
                v = v + 16'h0800;
            send_u(v);
        end
        repeat (3)
            send_beat(KIND_DATA, plain_text_byte());
        send_beat(KIND_DATA, CH_QUOTE);
        send_end();
    endtask

    // one random string: mostly well-formed pieces, some noise and cut-off input
    task automatic random_string();
        logic [15:0] v;
        int          n_tok;
        bit          cut;
        cut   = 1'b0;
        n_tok = $urandom_range(1, 8);
        if ($urandom_range(0, 19) == 0)
            send_beat(KIND_DATA, plain_text_byte());
        else
            send_beat(KIND_DATA, CH_QUOTE);
        for (int t = 0; t < n_tok && !cut; t++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: send_beat(KIND_DATA, plain_text_byte());
                4, 5: begin
                    send_beat(KIND_DATA, CH_BSLASH);
                    send_beat(KIND_DATA, ESC_LETTERS[$urandom_range(0, N_ESC - 1)]);
                end
                6: send_u(16'($urandom_range(16'h0000, 16'h007F)));
                7: send_u(16'($urandom_range(16'h0080, 16'h07FF)));
                8, 9: begin
                    v = 16'($urandom_range(16'h0800, 16'hF7FF));
                    if (v >= HI_SUR_LO)
                        v = v + 16'h0800;
                    send_u(v);
                end
                10, 11: begin
                    send_u(16'(HI_SUR_LO + $urandom_range(0, 1023)));
                    send_u(16'(LO_SUR_LO + $urandom_range(0, 1023)));
                end
                12: send_u(16'(HI_SUR_LO + $urandom_range(0, 1023)));
                13: send_u(16'(LO_SUR_LO + $urandom_range(0, 1023)));
                14: send_u(16'($urandom));
                default: begin
                    // noise: bad escape, bad hex, or input cut inside an escape
                    case ($urandom_range(0, 3))
                        0: begin
                            send_beat(KIND_DATA, CH_BSLASH);
                            send_beat(KIND_DATA, bad_escape_letter());
                        end
                        1: begin
                            send_beat(KIND_DATA, CH_BSLASH);
                            send_beat(KIND_DATA, CH_LC_U);
                            repeat ($urandom_range(0, 3))
                                send_beat(KIND_DATA, hex_char(4'($urandom)));
                            send_beat(KIND_DATA, bad_hex_char());
                        end
                        2: begin
                            send_beat(KIND_DATA, CH_BSLASH);
                            send_beat(KIND_DATA, CH_LC_U);
                            repeat ($urandom_range(0, 3))
                                send_beat(KIND_DATA, hex_char(4'($urandom)));
                            cut = 1'b1;
                        end
                        default: begin
                            send_beat(KIND_DATA, CH_BSLASH);
                            cut = 1'b1;
                        end
                    endcase
                end
            endcase
        end
        if (!cut && $urandom_range(0, 9) != 0) begin
            send_beat(KIND_DATA, CH_QUOTE);
            repeat ($urandom_range(0, 2))
                send_beat(KIND_DATA, 8'($urandom_range(0, 255)));
        end
        send_end();
    endtask

    task automatic test_random_text();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            random_string();
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin : main_seq
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_DATA;
        in_ch.data_byte = 8'h00;
        rst_n           = 1'b0;
        clear_decoder();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_framing();
        wait_drained();
        test_simple_escapes();
        test_code_unit_widths();
        wait_drained();
        test_surrogate_pairs();
        test_unpaired_surrogates();
        wait_drained();
        test_error_cases();
        test_output_backpressure();
        wait_drained();
        test_random_text();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_utf8.size() != 0)
            note_failure($sformatf("%0d expected beats never arrived", expected_utf8.size()));

        $display("covered %0d input beats and %0d result beats (%0d strings closed, %0d errors)",
                 items_sent, results_seen, strings_closed, error_reports);
        $display("mismatches: %0d", fail_cnt);
        if (fail_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/jsu_pkg.sv
src/jsu_if.sv
src/jsu_front.sv
src/jsu_fifo.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
test/tb_top.sv
